FILE: hdl/crx_pkg.sv
// Package for the character range expander.
// Holds item types, character class codes, state encoding and control structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crx_pkg;

  localparam logic [7:0] DASH_CHAR = 8'h2D;

  // Character classes that can open a range
  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_DIGIT = 2'd1,
    CLS_UPPER = 2'd2,
    CLS_LOWER = 2'd3
  } class_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
    logic       string_end;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
    logic final_item;
    logic no_result;
  } dp_status_t;

  function automatic class_t char_class(input logic [7:0] c);
    class_t cls;
    cls = CLS_NONE;
    if (c >= 8'h30 && c <= 8'h39) begin
      cls = CLS_DIGIT;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      cls = CLS_UPPER;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      cls = CLS_LOWER;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/crx_stream_if.sv
// Valid/ready stream channel for the character range expander.
// Payload type is a parameter; the item types live in crx_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface crx_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

FILE: hdl/crx_ctrl.sv
// Controller state machine of the character range expander.
// Sequences item acceptance and result emission; uses crx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crx_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire crx_pkg::dp_status_t status,
  output crx_pkg::ctrl_cmd_t      cmd
);

  crx_pkg::state_t state;
  crx_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crx_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      crx_pkg::ST_IDLE: begin
        if (cmd.accept && !status.no_result) begin
          state_next = crx_pkg::ST_EMIT;
        end
      end
      crx_pkg::ST_EMIT: begin
        if (cmd.emit && status.final_item) begin
          if (cmd.accept && !status.no_result) begin
            state_next = crx_pkg::ST_EMIT;
          end else begin
            state_next = crx_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = crx_pkg::ST_IDLE;
    endcase
  end

  // Outputs: take a new item when idle or as the last result of a run leaves
  always_comb begin
    in_ready   = 1'b0;
    cmd.emit   = 1'b0;
    unique case (state)
      crx_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      crx_pkg::ST_EMIT: begin
        cmd.emit = status.slot_free;
        in_ready = status.slot_free && status.final_item;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.accept = in_valid && in_ready;
  end

  // A run that is not finished keeps the controller emitting
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && !status.final_item |=> state == crx_pkg::ST_EMIT)
    else $error("run left emit state before its last result");

  // An item that produces results always leads to emission
  a_accept_emits: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && !status.no_result |=> state == crx_pkg::ST_EMIT)
    else $error("accepted item with results did not start emission");

  // While emitting, a new item enters only on the last result of the run
  a_accept_on_final: assert property (@(posedge clk) disable iff (rst)
    state == crx_pkg::ST_EMIT && cmd.accept |-> cmd.emit && status.final_item)
    else $error("item accepted in the middle of a run");

endmodule

`default_nettype wire

FILE: hdl/crx_dp.sv
// Datapath of the character range expander.
// Holds character history, the run being emitted and the output register; uses crx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crx_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire crx_pkg::ctrl_cmd_t  cmd,
  output crx_pkg::dp_status_t      status,
  input  wire crx_pkg::in_item_t   in_item,
  output crx_pkg::out_item_t       out_item,
  output logic                     out_valid,
  input  wire logic                out_ready
);

  // Character history
  logic [7:0]      prev_char;
  logic [7:0]      range_start;
  logic            dash_pending;
  crx_pkg::class_t range_class;
  logic            seen_any;

  // Run being emitted: optional leading dash, then cur up to end_char
  logic       lead;
  logic [7:0] cur;
  logic [7:0] end_char;
  logic       run_last;

  // Plan for the incoming item
  logic       plan_lead;
  logic [7:0] plan_cur;
  logic [7:0] plan_end;
  logic       plan_none;
  logic       hold_dash;

  crx_pkg::class_t in_cls;
  crx_pkg::class_t prev_cls;
  logic            in_dash;

  assign in_cls   = crx_pkg::char_class(in_item.in_char);
  assign prev_cls = crx_pkg::char_class(prev_char);
  assign in_dash  = (in_item.in_char == crx_pkg::DASH_CHAR);

  // Decide what the incoming item emits
  always_comb begin
    plan_lead = 1'b0;
    plan_cur  = in_item.in_char;
    plan_end  = in_item.in_char;
    plan_none = 1'b0;
    hold_dash = 1'b0;
    if (dash_pending) begin
      if (in_dash) begin
        plan_lead = 1'b1;
      end else if (in_cls != crx_pkg::CLS_NONE && in_cls == range_class) begin
        if (in_item.in_char > range_start) begin
          plan_cur = range_start + 8'd1;
        end
      end else begin
        plan_lead = 1'b1;
      end
    end else if (in_dash && seen_any && prev_cls != crx_pkg::CLS_NONE) begin
      hold_dash = 1'b1;
      plan_none = !in_item.in_last;
    end
  end

  assign status.slot_free  = !out_valid || out_ready;
  assign status.final_item = !lead && (cur == end_char);
  assign status.no_result  = plan_none;

  // Update character history on each accepted item; clear it after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_char    <= '0;
      range_start  <= '0;
      dash_pending <= 1'b0;
      range_class  <= crx_pkg::CLS_NONE;
      seen_any     <= 1'b0;
    end else if (cmd.accept) begin
      if (in_item.in_last) begin
        prev_char    <= '0;
        range_start  <= '0;
        dash_pending <= 1'b0;
        range_class  <= crx_pkg::CLS_NONE;
        seen_any     <= 1'b0;
      end else begin
        prev_char <= in_item.in_char;
        seen_any  <= 1'b1;
        if (dash_pending) begin
          dash_pending <= 1'b0;
          range_class  <= crx_pkg::CLS_NONE;
        end else if (hold_dash) begin
          dash_pending <= 1'b1;
          range_start  <= prev_char;
          range_class  <= prev_cls;
        end
      end
    end
  end

  // Load a new run on accept, otherwise advance the current one
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lead     <= plan_lead;
      cur      <= plan_cur;
      end_char <= plan_end;
      run_last <= in_item.in_last;
    end else if (cmd.emit) begin
      if (lead) begin
        lead <= 1'b0;
      end else begin
        cur <= cur + 8'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.out_char   <= lead ? crx_pkg::DASH_CHAR : cur;
      out_item.run_end    <= status.final_item;
      out_item.string_end <= status.final_item && run_last;
    end
  end

  // A held dash stays held into the next item
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && status.no_result |=> dash_pending)
    else $error("held dash not recorded");

  // The end of a string returns the history to its reset value
  a_string_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && in_item.in_last |=> !dash_pending && !seen_any)
    else $error("history not cleared after last item of string");

  // A pending dash always knows the class of its range start
  a_pending_class: assert property (@(posedge clk) disable iff (rst)
    dash_pending |-> range_class != crx_pkg::CLS_NONE)
    else $error("dash pending without a range class");

  // Inside a run the character climbs by one per result
  a_run_step: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && !status.final_item && !lead |=> cur == $past(cur) + 8'd1)
    else $error("run did not advance by one");

endmodule

`default_nettype wire

FILE: hdl/char_range_expander.sv
// Character range expander: expands shorthand ranges such as a-z in a byte stream.
// An accepted item loads the run registers; each of its results then passes through the
// output register, which holds it while the output is stalled.
// Throughput, while the output is not stalled: one item per cycle for characters that pass
// through; a range of up to 25 results holds the input until its last result is emitted,
// one per cycle by the emit counter. A held dash gives no result unless it ends a string.
// Reset (rst, synchronous): clears history, the controller and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module char_range_expander (
  input  wire logic     clk,
  input  wire logic     rst,
  crx_stream_if.sink    din,
  crx_stream_if.source  dout
);

  crx_pkg::ctrl_cmd_t  cmd;
  crx_pkg::dp_status_t status;

  // Sequencing
  crx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // History, run counter and output register
  crx_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (din.payload),
    .out_item  (dout.payload),
    .out_valid (dout.valid),
    .out_ready (dout.ready)
  );

endmodule

`default_nettype wire
